[sv/paid_pkg.sv]
// Shared types and constants for the packed array insert/delete block.
package paid_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int ELEM_BYTES_DEF = 4;

  localparam int OP_W      = 3;
  localparam int IDX_W     = 6;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 7;
  localparam int CAP_W     = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_MODIFY = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
    logic wr;
    logic clr;
  } cell_cmd_t;

endpackage

[sv/paid_in_if.sv]
// Request channel: operation, index and value with valid/ready.
interface paid_in_if;
  import paid_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [IDX_W-1:0] index;
  logic [VAL_W-1:0] value;

  modport source (output valid, operation, index, value, input ready);
  modport sink   (input valid, operation, index, value, output ready);
endinterface

[sv/paid_out_if.sv]
// Result channel: ok flag, read value and element count with valid/ready.
interface paid_out_if;
  import paid_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [VAL_W-1:0]     read_value;
  logic [CNT_OUT_W-1:0] count;

  modport source (output valid, ok, read_value, count, input ready);
  modport sink   (input valid, ok, read_value, count, output ready);
endinterface

[sv/paid_cell.sv]
// One element slot of the shifting array; trades data with its neighbors.
module paid_cell #(
  parameter int IDX   = 0,
  parameter int EW    = 32,
  parameter int CMP_W = 7
) (
  input  logic               clk,
  input  paid_pkg::cell_cmd_t cmd,
  input  logic [CMP_W-1:0]   cmd_idx,
  input  logic [CMP_W-1:0]   cmd_cnt,
  input  logic [EW-1:0]      wr_data,
  input  logic [EW-1:0]      left_data,
  input  logic [EW-1:0]      right_data,
  output logic [EW-1:0]      slot_q,
  output logic [EW-1:0]      rd_data
);
  import paid_pkg::*;

  localparam logic [CMP_W-1:0] MY_IDX  = CMP_W'(IDX);
  localparam logic [CMP_W-1:0] MY_IDX1 = CMP_W'(IDX + 1);

  logic [EW-1:0] slot_r;
  logic [EW-1:0] slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    if (cmd.clr) begin
      slot_nxt = '0;
    end else if (cmd.ins) begin
      if (MY_IDX == cmd_idx) begin
        slot_nxt = wr_data;
      end else if (MY_IDX > cmd_idx && MY_IDX <= cmd_cnt) begin
        slot_nxt = left_data;
      end
    end else if (cmd.del) begin
      if (MY_IDX1 == cmd_cnt) begin
        slot_nxt = '0;
      end else if (MY_IDX >= cmd_idx && MY_IDX1 < cmd_cnt) begin
        slot_nxt = right_data;
      end
    end else if (cmd.wr) begin
      if (MY_IDX == cmd_idx) begin
        slot_nxt = wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot_q  = slot_r;
  assign rd_data = (MY_IDX == cmd_idx) ? slot_r : '0;

endmodule

[sv/packed_array_insert_delete.sv]
// Top level of the packed array: command decode, row of slot cells, result register.
//
//   channel | dir | handshake        | payload
//   in_ch   | in  | valid/ready      | operation[2:0] index[5:0] value[31:0]
//   out_ch  | out | valid/ready      | ok read_value[31:0] count[6:0]
//   cfg     | in  | cfg_we           | cfg_wdata[6:0] = capacity
//
// Every operation is applied at the accepting edge: all cells shift in parallel at that edge.
// The result sits in an output register; a new transaction is taken while it is taken or empty.
// An unconsumed result stalls the input side.
// Synchronous active-low reset empties the array and sets capacity to 64; no clearing pass.
module packed_array_insert_delete #(
  parameter int DEPTH      = paid_pkg::DEPTH_DEF,
  parameter int ELEM_BYTES = paid_pkg::ELEM_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  paid_in_if.sink                    in_ch,
  paid_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [paid_pkg::CAP_W-1:0] cfg_wdata
);
  import paid_pkg::*;

  localparam int EW    = ELEM_BYTES * 8;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

  logic [CAP_W-1:0]     cap_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     cnt_nxt;
  logic                 out_valid_r;
  logic                 ok_r;
  logic [VAL_W-1:0]     rdv_r;
  logic [CNT_OUT_W-1:0] cnt_out_r;

  logic                 acc;
  logic [CMP_W-1:0]     cnt_w;
  logic [CMP_W-1:0]     cap_w;
  logic [CMP_W-1:0]     cap_eff;
  logic [CMP_W-1:0]     idx_w;
  logic [CMP_W-1:0]     cnt_nxt_w;
  logic                 ok_c;
  logic                 idx_valid;
  logic                 ins_ok;
  cell_cmd_t            cmd;
  logic [EW-1:0]        wr_data;
  logic [EW-1:0]        rd_sel;
  logic [VAL_W-1:0]     rd_low;
  logic [VAL_W-1:0]     rdv_c;

  logic [EW-1:0] slot_q  [DEPTH];
  logic [EW-1:0] rd_part [DEPTH];
  logic [EW-1:0] rd_acc  [DEPTH];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;

  assign cnt_w   = CMP_W'(cnt_r);
  assign cap_w   = CMP_W'(cap_r);
  assign cap_eff = (cap_w > DEPTH_C) ? DEPTH_C : cap_w;
  assign idx_w   = CMP_W'(in_ch.index);

  assign idx_valid = idx_w < cnt_w;
  assign ins_ok    = (cnt_w < cap_eff) && (idx_w < cap_eff) && (idx_w <= cnt_w) &&
                     (cnt_w < DEPTH_C);

  always_comb begin
    ok_c    = 1'b0;
    cmd     = '0;
    cnt_nxt = cnt_r;
    case (op_e_t'(in_ch.operation))
      OP_INSERT: begin
        ok_c    = ins_ok;
        cmd.ins = ins_ok && acc;
        if (ins_ok) cnt_nxt = cnt_r + 1'b1;
      end
      OP_DELETE: begin
        ok_c    = idx_valid;
        cmd.del = idx_valid && acc;
        if (idx_valid) cnt_nxt = cnt_r - 1'b1;
      end
      OP_MODIFY: begin
        ok_c   = idx_valid;
        cmd.wr = idx_valid && acc;
      end
      OP_READ: begin
        ok_c = idx_valid;
      end
      OP_CLEAR: begin
        ok_c    = 1'b1;
        cmd.clr = acc;
        cnt_nxt = '0;
      end
      default: begin
        ok_c = 1'b0;
      end
    endcase
  end

  assign cnt_nxt_w = CMP_W'(cnt_nxt);

  generate
    if (EW >= VAL_W) begin : g_wide
      assign wr_data = EW'(in_ch.value);
      assign rd_low  = rd_sel[VAL_W-1:0];
    end else begin : g_narrow
      assign wr_data = in_ch.value[EW-1:0];
      assign rd_low  = VAL_W'(rd_sel);
    end
  endgenerate

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [EW-1:0] left_d;
      logic [EW-1:0] right_d;
      if (gi == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_mid_l
        assign left_d = slot_q[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_d = '0;
      end else begin : g_mid_r
        assign right_d = slot_q[gi+1];
      end

      paid_cell #(
        .IDX   (gi),
        .EW    (EW),
        .CMP_W (CMP_W)
      ) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .cmd_idx    (idx_w),
        .cmd_cnt    (cnt_w),
        .wr_data    (wr_data),
        .left_data  (left_d),
        .right_data (right_d),
        .slot_q     (slot_q[gi]),
        .rd_data    (rd_part[gi])
      );

      if (gi == 0) begin : g_or0
        assign rd_acc[gi] = rd_part[gi];
      end else begin : g_orn
        assign rd_acc[gi] = rd_acc[gi-1] | rd_part[gi];
      end
    end
  endgenerate

  assign rd_sel = rd_acc[DEPTH-1];
  assign rdv_c  = (ok_c && op_e_t'(in_ch.operation) == OP_READ) ? rd_low : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      if (acc) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      ok_r      <= ok_c;
      rdv_r     <= rdv_c;
      cnt_out_r <= cnt_nxt_w[CNT_OUT_W-1:0];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ok         = ok_r;
  assign out_ch.read_value = rdv_r;
  assign out_ch.count      = cnt_out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_w <= DEPTH_C)
    else $error("element count above depth");

  a_acc_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid_r)
    else $error("accepted transaction produced no result");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    acc && op_e_t'(in_ch.operation) == OP_CLEAR |=> ok_r && cnt_r == '0)
    else $error("clear did not empty the array");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !ok_r |-> rdv_r == '0)
    else $error("rejected result carries read data");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    acc && op_e_t'(in_ch.operation) != OP_CLEAR |=>
      cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + 1'b1 ||
      cnt_r == $past(cnt_r) - 1'b1)
    else $error("count moved by more than one");

endmodule
